// ===== rtl/core/sdf_pkg.sv =====
// Shared types and constants for the sequence-number duplicate filter.
// No dependencies; imported by sdf_scan and seqnum_duplicate_filter.
package sdf_pkg;

  // Field widths
  localparam int unsigned NUM_W  = 16;
  localparam int unsigned AGE_W  = 16;
  localparam int unsigned WIN_W  = 12;
  localparam int unsigned ENT_W  = NUM_W + AGE_W;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // Command opcodes
  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = 12'd20;
  localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd500;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_CHECK,
    ST_FINISH
  } state_e;

  // What the table scan found
  typedef struct packed {
    logic succ_found;
    logic pred_found;
    logic free_found;
  } scan_flags_t;

endpackage

// ===== rtl/core/sdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the table of numbers and ages.
module sdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/sdf_scan.sv =====
// Scan unit: takes one table entry per cycle while sample_i is high and keeps
// the running successor, predecessor, oldest live entry and first free slot. Depends on sdf_pkg.
module sdf_scan
  import sdf_pkg::*;
#(
  parameter int unsigned IDX_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              sample_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [AGE_W-1:0]  age_i,
  input  logic [NUM_W-1:0]  key_i,
  input  logic [AGE_W-1:0]  timeout_i,
  output logic              expire_o,
  output scan_flags_t       flags_o,
  output logic [IDX_W-1:0]  succ_idx_o,
  output logic [NUM_W-1:0]  succ_num_o,
  output logic [IDX_W-1:0]  pred_idx_o,
  output logic [NUM_W-1:0]  pred_num_o,
  output logic [IDX_W-1:0]  free_idx_o,
  output logic [IDX_W-1:0]  old_idx_o
);

  scan_flags_t      flags_q, flags_d;
  logic             old_found_q, old_found_d;
  logic [IDX_W-1:0] succ_idx_q, succ_idx_d, pred_idx_q, pred_idx_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d, old_idx_q, old_idx_d;
  logic [NUM_W-1:0] succ_num_q, succ_num_d, pred_num_q, pred_num_d;
  logic [AGE_W-1:0] old_age_q, old_age_d;
  logic             aged_out, live;

  assign aged_out = valid_i && (age_i > timeout_i);
  assign live     = valid_i && !(age_i > timeout_i);
  assign expire_o = sample_i && aged_out;

  // Running selection over the entries seen so far
  always_comb begin
    flags_d     = flags_q;
    old_found_d = old_found_q;
    succ_idx_d  = succ_idx_q;
    succ_num_d  = succ_num_q;
    pred_idx_d  = pred_idx_q;
    pred_num_d  = pred_num_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    old_age_d   = old_age_q;
    if (clear_i) begin
      flags_d     = '0;
      old_found_d = 1'b0;
    end else if (sample_i) begin
      if (!live) begin
        if (!flags_q.free_found) begin
          flags_d.free_found = 1'b1;
          free_idx_d         = idx_i;
        end
      end else begin
        // smallest number at or above the key
        if (num_i >= key_i && (!flags_q.succ_found || num_i < succ_num_q)) begin
          flags_d.succ_found = 1'b1;
          succ_idx_d         = idx_i;
          succ_num_d         = num_i;
        end
        // largest number below the key, i.e. below the successor
        if (num_i < key_i && (!flags_q.pred_found || num_i > pred_num_q)) begin
          flags_d.pred_found = 1'b1;
          pred_idx_d         = idx_i;
          pred_num_d         = num_i;
        end
        // oldest live entry, lowest index wins a tie
        if (!old_found_q || age_i > old_age_q) begin
          old_found_d = 1'b1;
          old_idx_d   = idx_i;
          old_age_d   = age_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      old_found_q <= 1'b0;
    end else begin
      flags_q     <= flags_d;
      old_found_q <= old_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    succ_idx_q <= succ_idx_d;
    succ_num_q <= succ_num_d;
    pred_idx_q <= pred_idx_d;
    pred_num_q <= pred_num_d;
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    old_age_q  <= old_age_d;
  end

  assign flags_o    = flags_q;
  assign succ_idx_o = succ_idx_q;
  assign succ_num_o = succ_num_q;
  assign pred_idx_o = pred_idx_q;
  assign pred_num_o = pred_num_q;
  assign free_idx_o = free_idx_q;
  assign old_idx_o  = old_idx_q;

endmodule

// ===== rtl/core/seqnum_duplicate_filter.sv =====
// Top level of the sequence-number duplicate filter: sequencer, valid bits,
// configuration registers. Depends on sdf_pkg, sdf_ram and sdf_scan.
//
//  channel   direction  transfer condition           payload
//  command   in         start & !busy                opcode_i, seq_num_i
//  result    out        result_valid_o (one cycle)   is_new_o, evicted_o
//  config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// A check walks the table one entry per cycle through the single RAM read
// port and the scan unit, then decides and writes in ST_FINISH; the result
// is strobed in the cycle after ST_FINISH, once busy has fallen.
// A tick walks the table the same way, with no decision step.
// A clear takes effect at the transfer edge; busy never rises for it.
// Reset empties the table and loads window 20 and timeout 500; no sweep.
// The result port cannot stall; each result is shown for one cycle only.
module seqnum_duplicate_filter
  import sdf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            opcode_i,
  input  logic [NUM_W-1:0]      seq_num_i,
  output logic                  result_valid_o,
  output logic                  is_new_o,
  output logic                  evicted_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         rd_cnt_q, rd_cnt_d;
  logic                     pipe_vld_q;
  logic [IDX_W-1:0]         pipe_idx_q;
  logic [NUM_W-1:0]         num_q, num_d;
  logic [WIN_W-1:0]         window_q;
  logic [AGE_W-1:0]         timeout_q;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic                     res_vld_q, res_vld_d, is_new_q, is_new_d;
  logic                     evicted_q, evicted_d;

  logic                     accept, issue, scanning, scan_clear, scan_sample;
  logic [IDX_W-1:0]         raddr;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENT_W-1:0]         ram_wdata, ram_rdata;
  logic [NUM_W-1:0]         ent_num;
  logic [AGE_W-1:0]         ent_age;
  logic                     ent_valid;

  logic                     expire;
  scan_flags_t              flags;
  logic [IDX_W-1:0]         succ_idx, pred_idx, free_idx, old_idx, slot_idx;
  logic [NUM_W-1:0]         succ_num, pred_num;
  logic [NUM_W:0]           key_plus_win, pred_plus_win;
  logic                     is_dup, drop_pred;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  assign scanning = (state_q == ST_TICK) || (state_q == ST_CHECK);
  assign issue    = scanning && (rd_cnt_q != CNT_END);
  assign raddr    = rd_cnt_q[IDX_W-1:0];

  assign ent_num   = ram_rdata[ENT_W-1:AGE_W];
  assign ent_age   = ram_rdata[AGE_W-1:0];
  assign ent_valid = valid_q[pipe_idx_q];

  assign scan_clear  = accept && (opcode_i == OP_CHECK);
  assign scan_sample = pipe_vld_q && (state_q == ST_CHECK);

  sdf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  sdf_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .sample_i   (scan_sample),
    .idx_i      (pipe_idx_q),
    .valid_i    (ent_valid),
    .num_i      (ent_num),
    .age_i      (ent_age),
    .key_i      (num_q),
    .timeout_i  (timeout_q),
    .expire_o   (expire),
    .flags_o    (flags),
    .succ_idx_o (succ_idx),
    .succ_num_o (succ_num),
    .pred_idx_o (pred_idx),
    .pred_num_o (pred_num),
    .free_idx_o (free_idx),
    .old_idx_o  (old_idx)
  );

  // Decision arithmetic, widened by one bit so nothing wraps
  assign key_plus_win  = {1'b0, num_q} + {{(NUM_W + 1 - WIN_W){1'b0}}, window_q};
  assign pred_plus_win = {1'b0, pred_num} + {{(NUM_W + 1 - WIN_W){1'b0}}, window_q};
  assign is_dup        = flags.succ_found && ({1'b0, succ_num} < key_plus_win);
  assign drop_pred     = flags.succ_found && flags.pred_found &&
                         (pred_plus_win > {1'b0, num_q});
  // a freed predecessor slot competes with the first free slot by index
  assign slot_idx      = (drop_pred && (!flags.free_found || pred_idx < free_idx)) ?
                         pred_idx : free_idx;

  // Sequencer, table writes and valid bits
  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    num_d     = num_q;
    valid_d   = valid_q;
    res_vld_d = 1'b0;
    is_new_d  = is_new_q;
    evicted_d = evicted_q;
    ram_we    = 1'b0;
    ram_waddr = pipe_idx_q;
    ram_wdata = {ent_num, ent_age + AGE_W'(1)};
    if (issue) begin
      rd_cnt_d = rd_cnt_q + CNT_W'(1);
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_cnt_d = '0;
          case (opcode_i)
            OP_CHECK: begin
              state_d = ST_CHECK;
              num_d   = seq_num_i;
            end
            OP_TICK:  state_d = ST_TICK;
            OP_CLEAR: valid_d = '0;
            default:  ;
          endcase
        end
      end
      ST_TICK: begin
        if (pipe_vld_q && ent_valid && (ent_age != AGE_MAX)) begin
          ram_we = 1'b1;
        end
        if (!issue) begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (expire) begin
          valid_d[pipe_idx_q] = 1'b0;
        end
        if (!issue) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d   = ST_IDLE;
        res_vld_d = 1'b1;
        is_new_d  = !is_dup;
        evicted_d = 1'b0;
        ram_we    = 1'b1;
        ram_wdata = {num_q, {AGE_W{1'b0}}};
        if (is_dup) begin
          // refresh the successor
          ram_waddr = succ_idx;
          ram_wdata = {succ_num, {AGE_W{1'b0}}};
        end else if (flags.succ_found && (succ_num == num_q)) begin
          // zero window: same number already stored, refresh only
          ram_waddr = succ_idx;
        end else if (flags.free_found || drop_pred) begin
          if (drop_pred) begin
            valid_d[pred_idx] = 1'b0;
          end
          ram_waddr         = slot_idx;
          valid_d[slot_idx] = 1'b1;
        end else begin
          ram_waddr = old_idx;
          evicted_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_cnt_q   <= '0;
      pipe_vld_q <= 1'b0;
      valid_q    <= '0;
      res_vld_q  <= 1'b0;
      window_q   <= WINDOW_RESET;
      timeout_q  <= TIMEOUT_RESET;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      pipe_vld_q <= issue;
      valid_q    <= valid_d;
      res_vld_q  <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_WINDOW:  window_q  <= cfg_data_i[WIN_W-1:0];
          CFG_TIMEOUT: timeout_q <= cfg_data_i[AGE_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= raddr;
    num_q      <= num_d;
    is_new_q   <= is_new_d;
    evicted_q  <= evicted_d;
  end

  assign result_valid_o = res_vld_q;
  assign is_new_o       = is_new_q;
  assign evicted_o      = evicted_q;

endmodule
